// ===== hdl/binary_max_heap_queue_top_macros.svh =====
// Assertion macros shared by the heap queue RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is high
`define BMHQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bmhq_pkg.sv =====
// Shared types, codes and defaults for the binary max-heap priority queue.
// No dependencies; used by the engine and the top level.
`default_nettype none

package bmhq_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 32;

   // Fixed widths of the channel fields
   localparam int KEY_W   = 32;
   localparam int TOP_W   = 32;
   localparam int COUNT_W = 7;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      action_type               action;
      logic signed [KEY_W-1:0]  key;
   } req_payload_type;

   typedef struct packed {
      logic signed [TOP_W-1:0]  top_value;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_empty;
      logic                     is_full;
      status_type               status;
   } rsp_payload_type;

   // Sift engine sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } eng_state_type;

   // Top level to engine
   typedef struct packed {
      logic start;   // request accepted this cycle
      logic take;    // finished result moves to the output register
   } eng_ctl_type;

   // Engine to top level
   typedef struct packed {
      logic idle;    // ready for a new request
      logic done;    // result waiting to be taken
   } eng_sts_type;

endpackage

`default_nettype wire

// ===== hdl/bmhq_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// No dependencies; the payload type is set where the channel is instantiated.
`default_nettype none

interface bmhq_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/binary_max_heap_queue_top.sv =====
// Binary max-heap priority queue: a request inserts a signed key or removes the
// largest one, and each request returns one response with the maximum held, the
// entry count, empty and full flags and a status (full insert or empty remove
// leaves the heap as it was). Keys live in a RAM of CAPACITY entries with two
// registered read ports; a sift moves one tree level per read and compare step
// through that RAM. An insert climbs until it reaches the root or meets a parent
// that is not smaller; a remove moves the last key to the root and sinks it
// until it reaches a leaf or no child is larger. Refused requests and the
// removal of the last key go straight to the result without a sift. A response
// that cannot leave the output register holds the engine until it does. One
// request is worked on at a time, and the next is taken while the previous
// response waits at the output.
// Depends on bmhq_pkg, bmhq_chan_if and bmhq_engine.
`default_nettype none

module binary_max_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bmhq_chan_if.sink  req_chan,
   bmhq_chan_if.source rsp_chan
);

   `include "binary_max_heap_queue_top_macros.svh"

   eng_ctl_type     ctl;
   eng_sts_type     sts;
   req_payload_type req_data;
   rsp_payload_type result;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   assign req_data = req_chan.payload;

   bmhq_engine #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .req    (req_data),
      .sts    (sts),
      .result (result)
   );

   // Take a request whenever the engine is free
   assign req_chan.ready = sts.idle;
   assign ctl.start      = req_chan.valid && sts.idle;

   // Move a finished result into the output register once it is free
   assign ctl.take = sts.done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `BMHQ_ASSERT(a_start_leaves_idle, clock, reset,
      (req_chan.valid && req_chan.ready) |=> !sts.idle,
      "engine still idle after a request was taken")

endmodule

`default_nettype wire

// ===== hdl/bmhq_ram.sv =====
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, and register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== hdl/bmhq_engine.sv =====
// Sift engine: holds the heap store RAM, the fill count and the root copy,
// and runs sift-up on insert and sift-down on remove. Depends on bmhq_pkg, bmhq_ram.
`default_nettype none

module bmhq_engine
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire eng_ctl_type     ctl,
   input  wire req_payload_type req,
   output      eng_sts_type     sts,
   output      rsp_payload_type result
);

   `include "binary_max_heap_queue_top_macros.svh"

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CW     = ADDR_W + 2;

   eng_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [KEY_BITS-1:0] cur_ff, cur_in;
   logic [KEY_BITS-1:0] top_ff, top_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   status_type          status_ff, status_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
   logic [KEY_BITS-1:0] rd_data_a, rd_data_b;

   logic [KEY_BITS-1:0] key_ext;
   logic [ADDR_W-1:0]   parent;
   logic [CW-1:0]       lc_w, rc_w, count_w;
   logic                is_full_now, is_empty_now;
   logic                up_gt, lc_gt, rc_gt, lc_out;
   logic [KEY_BITS-1:0] best_l;

   bmhq_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Key taken at store width, sign extended or truncated
   assign key_ext = KEY_BITS'(req.key);

   // Tree addressing around the current node
   assign parent  = ADDR_W'((pos_ff - 1'b1) >> 1);
   assign lc_w    = {1'b0, pos_ff, 1'b1};
   assign rc_w    = lc_w + 1'b1;
   assign count_w = CW'(count_ff);
   assign lc_out  = (lc_w >= count_w);

   assign is_full_now  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty_now = (count_ff == '0);

   // Signed compares; ties never swap
   assign up_gt  = ($signed(cur_ff) > $signed(rd_data_a));
   assign lc_gt  = ($signed(rd_data_a) > $signed(cur_ff));
   assign best_l = lc_gt ? rd_data_a : cur_ff;
   assign rc_gt  = (rc_w < count_w) && ($signed(rd_data_b) > $signed(best_l));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               if (req.action == ACT_INSERT) begin
                  state_in = is_full_now ? ST_DONE : ST_UP_RD;
               end else if (is_empty_now || count_ff == CNT_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DN_LOAD;
               end
            end
         end
         ST_UP_RD:   state_in = (pos_ff == '0) ? ST_DONE : ST_UP_CMP;
         ST_UP_CMP:  state_in = up_gt ? ST_UP_RD : ST_DONE;
         ST_DN_LOAD: state_in = ST_DN_RD;
         ST_DN_RD:   state_in = lc_out ? ST_DONE : ST_DN_CMP;
         ST_DN_CMP:  state_in = (rc_gt || lc_gt) ? ST_DN_RD : ST_DONE;
         ST_DONE:    state_in = ctl.take ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and store accesses
   always_comb begin
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_addr_a = parent;
      rd_addr_b = ADDR_W'(rc_w);
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr_a = ADDR_W'(count_ff - 1'b1);
            if (ctl.start) begin
               status_in = STS_OK;
               if (req.action == ACT_INSERT) begin
                  if (is_full_now) begin
                     status_in = STS_FULL;
                  end else begin
                     cur_in   = key_ext;
                     pos_in   = ADDR_W'(count_ff);
                     count_in = count_ff + 1'b1;
                  end
               end else if (is_empty_now) begin
                  status_in = STS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (up_gt) begin
               wr_data = rd_data_a;
               pos_in  = parent;
            end
         end
         ST_DN_LOAD: begin
            // last entry becomes the moving key, starting at the root
            cur_in = rd_data_a;
            pos_in = '0;
         end
         ST_DN_RD: begin
            rd_addr_a = ADDR_W'(lc_w);
            if (lc_out) begin
               wr_en = 1'b1;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (rc_gt) begin
               wr_data = rd_data_b;
               pos_in  = ADDR_W'(rc_w);
            end else if (lc_gt) begin
               wr_data = rd_data_a;
               pos_in  = ADDR_W'(lc_w);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Keep a copy of the root in step with writes to entry zero
   assign top_in = (wr_en && wr_addr == '0) ? wr_data : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         status_ff <= STS_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      top_ff <= top_in;
   end

   // Status and result towards the top level
   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = (state_ff == ST_DONE);

   assign result.top_value   = is_empty_now ? '0 : TOP_W'(top_ff);
   assign result.entry_count = COUNT_W'(count_ff);
   assign result.is_empty    = is_empty_now;
   assign result.is_full     = is_full_now;
   assign result.status      = status_ff;

   `BMHQ_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(CAPACITY),
      "fill count beyond capacity")
   `BMHQ_ASSERT(a_write_below_count, clock, reset, wr_en |-> (CNT_W'(wr_addr) < count_ff),
      "store written at or above the fill count")
   `BMHQ_ASSERT(a_done_holds, clock, reset,
      (state_ff == ST_DONE && !ctl.take) |=> (state_ff == ST_DONE),
      "finished result dropped before it was taken")

endmodule

`default_nettype wire
